FILE: sv/centered_running_median_defines.svh
// assertion macros used by the checker file crm_checker.sv
`ifndef CENTERED_RUNNING_MEDIAN_DEFINES_SVH
`define CENTERED_RUNNING_MEDIAN_DEFINES_SVH

// same-cycle implication
`define CRM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("crm check failed");

// next-cycle implication
`define CRM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("crm check failed");

`endif

FILE: sv/crm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package crm_pkg;

    localparam int MAX_WINDOW  = 32;
    localparam int SAMPLE_BITS = 16;
    localparam int LEN_W       = $clog2(MAX_WINDOW + 1);
    localparam int PTR_W       = $clog2(MAX_WINDOW);
    localparam int ADDR_W      = 3;
    localparam int DATA_W      = 32;

    localparam logic [0:0]       REG_WINDOW_LEN   = 1'b0;
    localparam logic [LEN_W-1:0] WINDOW_LEN_RESET = LEN_W'(3);

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    typedef struct packed {
        logic    step;
        logic    del_en;
        logic    ins_en;
        sample_t del_val;
        sample_t ins_val;
    } cell_ctl_t;

    function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] v);
        logic [LEN_W-1:0] r;
        if (v == '0)
        begin
            r = LEN_W'(1);
        end
        else if (v > LEN_W'(MAX_WINDOW))
        begin
            r = LEN_W'(MAX_WINDOW);
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: sv/crm_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module crm_cell (
    input  wire logic               clk,
    input  wire crm_pkg::cell_ctl_t ctl,
    input  wire logic               occ_mid,
    input  wire crm_pkg::sample_t   right_val,
    input  wire crm_pkg::sample_t   left_sh,
    input  wire logic               left_le,
    output crm_pkg::sample_t        val,
    output crm_pkg::sample_t        sh,
    output logic                    le
);
    import crm_pkg::*;

    sample_t val_reg;
    sample_t val_next;
    logic    lt_del;

    // removal closes the gap from the right, insertion opens one to the right
    assign lt_del = val_reg < ctl.del_val;
    assign sh     = (ctl.del_en && !lt_del) ? right_val : val_reg;
    assign le     = occ_mid && (sh <= ctl.ins_val);

    always_comb
    begin
        if (!ctl.ins_en || le)
        begin
            val_next = sh;
        end
        else if (left_le)
        begin
            val_next = ctl.ins_val;
        end
        else
        begin
            val_next = left_sh;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.step)
        begin
            val_reg <= val_next;
        end
    end

    assign val = val_reg;

endmodule

`default_nettype wire

FILE: sv/crm_ring.sv
`timescale 1ns / 1ps
`default_nettype none

module crm_ring (
    input  wire logic                      clk,
    input  wire logic                      wr_en,
    input  wire logic [crm_pkg::PTR_W-1:0] wr_addr,
    input  wire crm_pkg::sample_t          wr_data,
    input  wire logic [crm_pkg::PTR_W-1:0] rd_addr,
    output crm_pkg::sample_t               rd_data
);
    import crm_pkg::*;

    sample_t mem [MAX_WINDOW];
    sample_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // write-first on a clash
    always_ff @(posedge clk)
    begin
        if (wr_en && (wr_addr == rd_addr))
        begin
            rd_data_reg <= wr_data;
        end
        else
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: sv/centered_running_median.sv
`timescale 1ns / 1ps
`default_nettype none

// port    dir   handshake             beat
// in      in    in_valid / in_ready   sample, last
// out     out   out_valid / out_ready median, last_out
// cfg     in    apb, pready tied high window_len at byte 0x0
//
// one sample per cycle while the output side keeps up; the sorted cell row
// removes the oldest sample and inserts the new one in the same cycle
// a median is taken from the registered row and leaves through the output register
// after a last beat the row drains one sample per cycle, input held off
// meanwhile; out_ready low stalls it
// rst_n clears all control state; window_len resets to 3

module centered_running_median (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [crm_pkg::ADDR_W-1:0] paddr,
    input  wire logic [crm_pkg::DATA_W-1:0] pwdata,
    output logic      [crm_pkg::DATA_W-1:0] prdata,
    output logic                            pready,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire crm_pkg::sample_t           sample,
    input  wire logic                       last,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output crm_pkg::sample_t                median,
    output logic                            last_out
);
    import crm_pkg::*;

    typedef enum logic {ST_RUN, ST_TAIL} state_t;

    state_t           state_reg, state_next;
    logic [LEN_W-1:0] fill_reg, fill_next;
    logic [LEN_W-1:0] active_len_reg, active_len_next;
    logic [LEN_W-1:0] window_len_reg;
    logic [PTR_W-1:0] rp_reg, rp_next;
    logic [PTR_W-1:0] tail_ptr_reg, tail_ptr_next;
    logic             pend_reg, pend_next;
    logic             out_valid_reg, out_valid_next;
    sample_t          median_reg;
    logic             last_out_reg;

    logic             cfg_wr;
    logic [LEN_W-1:0] len_cur;
    logic             adv_out;
    logic             accept;
    logic             del_run;
    logic [LEN_W-1:0] fill_acc;
    logic             emit_run;
    logic             pend_last;
    logic             tail_go;
    logic             tail_del;
    logic             load_out;
    logic [LEN_W-1:0] fill_mid;
    cell_ctl_t        ctl;

    sample_t          rd_data;
    logic [PTR_W-1:0] rd_addr;

    sample_t          cell_val [MAX_WINDOW];
    sample_t          cell_sh  [MAX_WINDOW];
    logic             cell_le  [MAX_WINDOW];

    logic [PTR_W-1:0]     half;
    logic [PTR_W-1:0]     mid_idx;
    sample_t              mid_lo;
    sample_t              mid_hi;
    logic [SAMPLE_BITS:0] mid_sum;
    sample_t              mid_val;

    // configuration
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_WINDOW_LEN) ? DATA_W'(window_len_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_len_reg <= WINDOW_LEN_RESET;
        end
        else if (cfg_wr && (paddr[2] == REG_WINDOW_LEN))
        begin
            window_len_reg <= pwdata[LEN_W-1:0];
        end
    end

    // step control
    assign len_cur   = (fill_reg == '0) ? clamp_len(window_len_reg) : active_len_reg;
    assign adv_out   = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_RUN) && (!pend_reg || adv_out);
    assign accept    = in_valid && in_ready;
    assign del_run   = (fill_reg == len_cur);
    assign fill_acc  = del_run ? fill_reg : fill_reg + LEN_W'(1);
    assign pend_last = (fill_acc == len_cur) || fill_acc[0];
    assign emit_run  = (fill_acc == len_cur)
                    || (fill_acc[0] && !(!len_cur[0] && (fill_acc == len_cur - LEN_W'(1))));
    assign tail_go   = (state_reg == ST_TAIL) && (!pend_reg || adv_out);
    assign tail_del  = tail_go && (fill_reg >= LEN_W'(2));
    assign load_out  = pend_reg && adv_out;

    always_comb
    begin
        ctl.step    = accept || tail_del;
        ctl.del_en  = accept ? del_run : 1'b1;
        ctl.ins_en  = accept;
        ctl.del_val = rd_data;
        ctl.ins_val = sample;
    end

    assign fill_mid = fill_reg - LEN_W'(ctl.del_en);

    always_comb
    begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        active_len_next = active_len_reg;
        rp_next         = rp_reg;
        tail_ptr_next   = tail_ptr_reg;
        pend_next       = pend_reg;
        case (state_reg)
            ST_RUN:
            begin
                if (load_out)
                begin
                    pend_next = 1'b0;
                end
                if (accept)
                begin
                    fill_next       = fill_acc;
                    active_len_next = len_cur;
                    rp_next         = rp_reg + PTR_W'(1);
                    if (last)
                    begin
                        state_next    = ST_TAIL;
                        pend_next     = pend_last;
                        tail_ptr_next = rp_reg + PTR_W'(1) - fill_acc[PTR_W-1:0];
                        rp_next       = '0;
                    end
                    else
                    begin
                        pend_next = emit_run;
                    end
                end
            end
            ST_TAIL:
            begin
                if (tail_go)
                begin
                    if (tail_del)
                    begin
                        fill_next     = fill_reg - LEN_W'(1);
                        pend_next     = !fill_reg[0];
                        tail_ptr_next = tail_ptr_reg + PTR_W'(1);
                    end
                    else
                    begin
                        state_next = ST_RUN;
                        fill_next  = '0;
                        pend_next  = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    assign rd_addr = (state_next == ST_TAIL) ? tail_ptr_next
                                             : rp_next - active_len_next[PTR_W-1:0];

    // median of the current row
    assign half    = fill_reg[LEN_W-1:1];
    assign mid_idx = fill_reg[0] ? half : half - PTR_W'(1);
    assign mid_lo  = cell_val[mid_idx];
    assign mid_hi  = cell_val[PTR_W'(mid_idx + PTR_W'(1))];
    assign mid_sum = {mid_lo[SAMPLE_BITS-1], mid_lo} + {mid_hi[SAMPLE_BITS-1], mid_hi};
    assign mid_val = fill_reg[0] ? mid_lo : sample_t'(mid_sum[SAMPLE_BITS:1]);

    assign out_valid_next = load_out ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_RUN;
            fill_reg       <= '0;
            active_len_reg <= WINDOW_LEN_RESET;
            rp_reg         <= '0;
            tail_ptr_reg   <= '0;
            pend_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            median_reg     <= '0;
            last_out_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fill_reg       <= fill_next;
            active_len_reg <= active_len_next;
            rp_reg         <= rp_next;
            tail_ptr_reg   <= tail_ptr_next;
            pend_reg       <= pend_next;
            out_valid_reg  <= out_valid_next;
            if (load_out)
            begin
                median_reg   <= mid_val;
                last_out_reg <= (state_reg == ST_TAIL) && (fill_reg == LEN_W'(1));
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign median    = median_reg;
    assign last_out  = last_out_reg;

    crm_ring u_ring (
        .clk     (clk),
        .wr_en   (accept),
        .wr_addr (rp_reg),
        .wr_data (sample),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // sorted row, smallest value in cell 0
    for (genvar i = 0; i < MAX_WINDOW; i++)
    begin : g_cell
        sample_t left_sh;
        logic    left_le;
        sample_t right_val;
        logic    occ_mid;

        if (i == 0)
        begin : g_first
            assign left_sh = '0;
            assign left_le = 1'b1;
        end
        else
        begin : g_inner_left
            assign left_sh = cell_sh[i-1];
            assign left_le = cell_le[i-1];
        end

        if (i == MAX_WINDOW - 1)
        begin : g_end
            assign right_val = '0;
        end
        else
        begin : g_inner_right
            assign right_val = cell_val[i+1];
        end

        assign occ_mid = LEN_W'(i) < fill_mid;

        crm_cell u_cell (
            .clk       (clk),
            .ctl       (ctl),
            .occ_mid   (occ_mid),
            .right_val (right_val),
            .left_sh   (left_sh),
            .left_le   (left_le),
            .val       (cell_val[i]),
            .sh        (cell_sh[i]),
            .le        (cell_le[i])
        );
    end

endmodule

`default_nettype wire

FILE: sv/crm_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "centered_running_median_defines.svh"

module crm_checker (
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       psel,
    input wire logic                       penable,
    input wire logic                       pwrite,
    input wire logic [crm_pkg::ADDR_W-1:0] paddr,
    input wire logic [crm_pkg::DATA_W-1:0] pwdata,
    input wire logic [crm_pkg::DATA_W-1:0] prdata,
    input wire logic                       pready,
    input wire logic                       in_valid,
    input wire logic                       in_ready,
    input wire crm_pkg::sample_t           sample,
    input wire logic                       last,
    input wire logic                       out_valid,
    input wire logic                       out_ready,
    input wire crm_pkg::sample_t           median,
    input wire logic                       last_out
);
    import crm_pkg::*;

    // a waiting result beat holds
    `CRM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(median) && $stable(last_out))

    // the drain after a last beat holds off input
    `CRM_ASSERT_NEXT(a_drain_blocks_input, in_valid && in_ready && last, !in_ready)

    // a write to the window register reads back
    `CRM_ASSERT_NEXT(a_cfg_readback, psel && penable && pwrite && pready && !paddr[2], paddr[2] || ((prdata[5:0] == $past(pwdata[5:0])) && (prdata[31:6] == 26'd0)))

endmodule

bind centered_running_median crm_checker u_crm_checker (.*);

`default_nettype wire

FILE: tb/sv/centered_running_median_checker.sv
`timescale 1ns / 1ps

module centered_running_median_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [crm_pkg::ADDR_W-1:0] paddr,
    input  logic [crm_pkg::DATA_W-1:0] pwdata,
    input  logic [crm_pkg::DATA_W-1:0] prdata,
    input  logic                       pready,
    input  logic                       in_valid,
    input  logic                       in_ready,
    input  crm_pkg::sample_t           sample,
    input  logic                       last,
    input  logic                       out_valid,
    input  logic                       out_ready,
    input  crm_pkg::sample_t           median,
    input  logic                       last_out,
    output int unsigned                errors,
    output int unsigned                pending,
    output int unsigned                checked
);

    import crm_pkg::*;

    localparam logic [ADDR_W-1:0] LEN_ADDR = ADDR_W'(4 * REG_WINDOW_LEN);

    typedef struct packed {
        sample_t median;
        logic    fin;
    } median_beat_t;

    sample_t          sorted_win [MAX_WINDOW];
    sample_t          ring_buf   [MAX_WINDOW];
    logic [PTR_W-1:0] ring_head;
    int               fill_cnt;
    int               seen_cnt;
    int               run_len;
    logic [LEN_W-1:0] len_reg;
    median_beat_t     median_q [$];
    median_beat_t     head_beat;

    task automatic report(input string what, input int got, input int want);
        $display("mismatch at output beat %0d: %s got %0d, expected %0d",
                 checked, what, got, want);
        errors++;
    endtask

    task automatic win_insert(input sample_t x);
        int p;
        int j;
        if (fill_cnt >= MAX_WINDOW)
        begin
            return;
        end
        p = 0;
        while (p < fill_cnt && sorted_win[p] <= x)
        begin
            p++;
        end
        for (j = fill_cnt; j > p; j--)
        begin
            sorted_win[j] = sorted_win[j-1];
        end
        sorted_win[p] = x;
        fill_cnt++;
    endtask

    task automatic win_remove(input sample_t x);
        int p;
        if (fill_cnt == 0)
        begin
            return;
        end
        p = 0;
        while (p < fill_cnt && sorted_win[p] != x)
        begin
            p++;
        end
        if (p >= fill_cnt)
        begin
            p = fill_cnt - 1;
        end
        for (; p + 1 < fill_cnt; p++)
        begin
            sorted_win[p] = sorted_win[p+1];
        end
        fill_cnt--;
    endtask

    // floor of the mean of the two middle entries for an even count
    function automatic sample_t win_middle(input int c);
        logic signed [SAMPLE_BITS:0] s;
        logic signed [SAMPLE_BITS:0] q;
        if (c == 0)
        begin
            return '0;
        end
        if (c % 2 == 1)
        begin
            return sorted_win[c/2];
        end
        s = {sorted_win[c/2-1][SAMPLE_BITS-1], sorted_win[c/2-1]}
          + {sorted_win[c/2][SAMPLE_BITS-1], sorted_win[c/2]};
        q = s >>> 1;
        return q[SAMPLE_BITS-1:0];
    endfunction

    task automatic queue_median(input sample_t v);
        median_beat_t b;
        b.median = v;
        b.fin    = 1'b0;
        median_q.push_back(b);
    endtask

    task automatic predict_medians(input sample_t x, input logic fin);
        int           win;
        int           c;
        int           r;
        int           n;
        median_beat_t b;
        if (seen_cnt == 0)
        begin
            win = int'(len_reg);
            if (win < 1)
            begin
                win = 1;
            end
            if (win > MAX_WINDOW)
            begin
                win = MAX_WINDOW;
            end
            run_len = win;
        end
        win = run_len;
        if (fill_cnt >= win)
        begin
            win_remove(ring_buf[(int'(ring_head) + MAX_WINDOW - win) % MAX_WINDOW]);
        end
        win_insert(x);
        if (seen_cnt < win)
        begin
            seen_cnt++;
        end
        ring_buf[ring_head] = x;
        ring_head = ring_head + 1'b1;
        c = fill_cnt;
        n = 0;
        if (!fin)
        begin
            if (c < win)
            begin
                // growing odd windows; an even window skips its last front position
                if ((c % 2 == 1) && !((win % 2 == 0) && (c == win - 1)))
                begin
                    queue_median(sorted_win[(c-1)/2]);
                end
            end
            else
            begin
                queue_median(win_middle(win));
            end
        end
        else
        begin
            if (c == win || c % 2 == 1)
            begin
                queue_median(win_middle(c));
                n++;
            end
            // tail: shrinking odd windows
            for (r = c; r >= 2; r--)
            begin
                win_remove(ring_buf[(int'(ring_head) + MAX_WINDOW - (r % MAX_WINDOW))
                                    % MAX_WINDOW]);
                if (r % 2 == 0)
                begin
                    queue_median(sorted_win[r/2-1]);
                    n++;
                end
            end
            if (n > 0)
            begin
                b = median_q.pop_back();
                b.fin = 1'b1;
                median_q.push_back(b);
            end
            ring_head = '0;
            fill_cnt  = 0;
            seen_cnt  = 0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            median_q.delete();
            ring_head = '0;
            fill_cnt  = 0;
            seen_cnt  = 0;
            run_len   = int'(WINDOW_LEN_RESET);
            len_reg   = WINDOW_LEN_RESET;
            errors    = 0;
            pending   = 0;
            checked   = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (median_q.size() == 0)
                begin
                    report("median beat with nothing expected", int'(median), 0);
                end
                else
                begin
                    head_beat = median_q.pop_front();
                    if (median !== head_beat.median)
                    begin
                        report("median", int'(median), int'(head_beat.median));
                    end
                    if (last_out !== head_beat.fin)
                    begin
                        report("last_out", int'(last_out), int'(head_beat.fin));
                    end
                end
                checked++;
            end
            if (psel && penable && pready && paddr == LEN_ADDR)
            begin
                if (pwrite)
                begin
                    len_reg = pwdata[LEN_W-1:0];
                end
                else if (prdata !== DATA_W'(len_reg))
                begin
                    report("window_len readback", int'(prdata), int'(len_reg));
                end
            end
            if (in_valid && in_ready)
            begin
                predict_medians(sample, last);
            end
            pending = median_q.size();
        end
    end

endmodule

FILE: tb/sv/centered_running_median_tb.sv
`timescale 1ns / 1ps

module centered_running_median_tb;

    import crm_pkg::*;

    localparam logic [ADDR_W-1:0] LEN_ADDR = ADDR_W'(4 * REG_WINDOW_LEN);

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                psel      = 1'b0;
    logic                penable   = 1'b0;
    logic                pwrite    = 1'b0;
    logic [ADDR_W-1:0]   paddr     = '0;
    logic [DATA_W-1:0]   pwdata    = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    sample_t             sample    = '0;
    logic                last      = 1'b0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    sample_t             median;
    logic                last_out;

    int unsigned         errors;
    int unsigned         pending;
    int unsigned         checked;

    int unsigned         send_idle_pct = 0;
    int unsigned         stall_pct     = 0;
    int unsigned         n_samples     = 0;
    int unsigned         n_series      = 0;
    int unsigned         n_settings    = 0;
    logic [LEN_W-1:0]    cur_len       = WINDOW_LEN_RESET;

    centered_running_median dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .sample    (sample),
        .last      (last),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .median    (median),
        .last_out  (last_out)
    );

    centered_running_median_checker median_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .sample    (sample),
        .last      (last),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .median    (median),
        .last_out  (last_out),
        .errors    (errors),
        .pending   (pending),
        .checked   (checked)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    initial
    begin
        #10_000_000;
        $display("timeout with %0d medians still expected", pending);
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic send_beat(input sample_t v, input logic fin);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        sample   <= v;
        last     <= fin;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        n_samples++;
        if (fin)
        begin
            n_series++;
        end
    endtask

    // let every expected median out, then allow for a tail drain still running
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (40)
        begin
            @(negedge clk);
        end
    endtask

    task automatic apb_access(input logic wr, input logic [LEN_W-1:0] v);
        logic [DATA_W-1:0] junk;
        junk = $urandom();
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= LEN_ADDR;
        pwdata  <= {junk[DATA_W-1:LEN_W], v};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_window(input logic [LEN_W-1:0] v);
        wait_idle();
        apb_access(1'b1, v);
        apb_access(1'b0, '0);
        cur_len = v;
        n_settings++;
    endtask

    task automatic random_series();
        int          eff;
        int          n;
        int          k;
        int unsigned style;
        sample_t     base;
        sample_t     v;
        eff = int'(cur_len);
        if (eff < 1)
        begin
            eff = 1;
        end
        if (eff > MAX_WINDOW)
        begin
            eff = MAX_WINDOW;
        end
        if ($urandom_range(0, 99) < 85)
        begin
            n = eff + int'($urandom_range(0, 10));
        end
        else if (eff > 1)
        begin
            n = int'($urandom_range(1, eff - 1));
        end
        else
        begin
            n = int'($urandom_range(1, 3));
        end
        style = $urandom_range(0, 2);
        base  = sample_t'($urandom());
        for (k = 0; k < n; k++)
        begin
            case (style)
                0:       v = sample_t'($urandom());
                1:       v = base + sample_t'($urandom_range(0, 6));
                default:
                begin
                    case ($urandom_range(0, 3))
                        0:       v = 16'sh7fff;
                        1:       v = 16'sh8000;
                        2:       v = -16'sd1;
                        default: v = '0;
                    endcase
                end
            endcase
            send_beat(v, k == n - 1);
        end
    endtask

    initial
    begin
        int unsigned mode;
        int unsigned start;
        int unsigned pick;

        repeat (6)
        begin
            @(negedge clk);
        end
        rst_n <= 1'b1;
        @(negedge clk);

        // reset window of 3: one-sample series, then extremes
        send_beat(16'sh8000, 1'b1);
        send_beat(16'sh7fff, 1'b0);
        send_beat(16'sh8000, 1'b0);
        send_beat(16'sh0000, 1'b0);
        send_beat(-16'sd1,   1'b0);
        send_beat(16'sh0001, 1'b1);

        // even window, negative pairs for the floor of the mean
        set_window(LEN_W'(4));
        send_beat(16'sh8000, 1'b0);
        send_beat(16'sh8001, 1'b0);
        send_beat(16'sd5,    1'b0);
        send_beat(-16'sd3,   1'b0);
        send_beat(-16'sd2,   1'b0);
        send_beat(16'sh7fff, 1'b1);
        // even-length series shorter than the window
        send_beat(-16'sd3,   1'b0);
        send_beat(-16'sd2,   1'b1);

        // zero acts as one, above the maximum acts as the maximum
        set_window(LEN_W'(0));
        send_beat(16'sh7fff, 1'b0);
        send_beat(16'sh8000, 1'b1);
        set_window(LEN_W'(63));
        send_beat(16'sd1,    1'b0);
        send_beat(-16'sd1,   1'b0);
        send_beat(16'sd1,    1'b1);

        // new length written part way through a series
        set_window(LEN_W'(2));
        send_beat(16'sd4,    1'b0);
        send_beat(-16'sd7,   1'b0);
        set_window(LEN_W'(5));
        send_beat(16'sd9,    1'b0);
        send_beat(-16'sd9,   1'b1);

        for (mode = 0; mode < 4; mode++)
        begin
            case (mode)
                0:       begin send_idle_pct = 0;  stall_pct = 0;  end
                1:       begin send_idle_pct = 86; stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  stall_pct = 86; end
                default: begin send_idle_pct = 25; stall_pct = 25; end
            endcase
            start = n_samples;
            while (n_samples - start < 65)
            begin
                if ($urandom_range(0, 99) < 45)
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 6)
                    begin
                        set_window(LEN_W'(0));
                    end
                    else if (pick < 11)
                    begin
                        set_window(LEN_W'(MAX_WINDOW));
                    end
                    else if (pick < 14)
                    begin
                        set_window(LEN_W'($urandom_range(MAX_WINDOW + 1, 63)));
                    end
                    else if (pick < 22)
                    begin
                        set_window(LEN_W'(1));
                    end
                    else if (pick < 27)
                    begin
                        set_window(LEN_W'($urandom_range(9, MAX_WINDOW - 1)));
                    end
                    else
                    begin
                        set_window(LEN_W'($urandom_range(2, 8)));
                    end
                end
                random_series();
            end
        end

        send_idle_pct = 0;
        stall_pct     = 0;
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (60)
        begin
            @(negedge clk);
        end

        $display("covered %0d series of %0d samples, %0d medians checked", n_series,
                 n_samples, checked);
        $display("%0d window settings incl. zero, one, the maximum and beyond, four idle mixes",
                 n_settings);
        if (errors == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+sv
sv/crm_pkg.sv
sv/crm_cell.sv
sv/crm_ring.sv
sv/centered_running_median.sv
sv/crm_checker.sv
tb/sv/centered_running_median_checker.sv
tb/sv/centered_running_median_tb.sv
